// ===== rtl/progressive_accumulate_tonemap_pack_assert.svh =====
// assertion macros for the accumulate and tone map block
`ifndef PROGRESSIVE_ACCUMULATE_TONEMAP_PACK_ASSERT_SVH
`define PROGRESSIVE_ACCUMULATE_TONEMAP_PACK_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during rst
`define PATP_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("patp: implication check failed");
// next-cycle implication, sampled on clk, off during rst
`define PATP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("patp: next-cycle check failed");
`else
`define PATP_ASSERT_IMPLY(name, ante, cons)
`define PATP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/patp_pkg.sv =====
// constants and types for the accumulate and tone map block
`default_nettype none
package patp_pkg;
  localparam int NCH         = 3;
  localparam int COORD_W     = 13;
  localparam int DIV_STEPS   = 24;
  localparam int CURVE_STEPS = 8;

  localparam logic [7:0]  ALPHA_RESET  = 8'd255;
  // curve constants in q16 (q32 for the denominator offset)
  localparam logic [23:0] Q_OFFSET     = 24'd262;
  localparam logic [18:0] Q_SIX_TWO    = 19'd406323;
  localparam logic [27:0] Q_HALF       = 28'd32768;
  localparam logic [27:0] Q_ONE_SEVEN  = 28'd111411;
  localparam logic [52:0] Q32_ZERO_SIX = 53'd257698038;

  typedef logic [23:0] hdr_t;
endpackage
`default_nettype wire

// ===== rtl/progressive_accumulate_tonemap_pack.sv =====
// top level: per-pixel hdr running mean, filmic tone curve and rgba8 packing
// Usage:
//   sample channel (sample_valid / sample_stall) carries one hdr sample with its
//   pixel coordinates and the count of samples already folded into that pixel.
//   result channel (result_valid / result_stall) returns the flipped display
//   address and the packed rgba word, one result per sample, in order.
//   cfg_write loads alpha_byte, used as bits 7..0 of every following result.
// Timing:
//   one sample per cycle is sustained while results are not stalled and
//   consecutive samples hit different pixels; the accumulation memory is
//   read, blended through a 24-step divider and written back, so a sample
//   for a pixel still inside that read-modify-write window waits until the
//   earlier write lands.
// Reset: clears all pipeline valids and sets alpha to 255; the accumulation
//   memory is not cleared, a count of zero starts a pixel afresh.
// Stall: a stalled result freezes the pipeline from stage b on; sample_stall rises
//   once the input and address registers both hold a sample and b cannot move.
`default_nettype none
`include "progressive_accumulate_tonemap_pack_assert.svh"
module progressive_accumulate_tonemap_pack #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  alpha_byte,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [9:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  input  logic [15:0] sample_count,
  input  logic [23:0] sample_red,
  input  logic [23:0] sample_green,
  input  logic [23:0] sample_blue,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [18:0] pixel_address,
  output logic [31:0] rgba_word
);
  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int DS  = patp_pkg::DIV_STEPS;
  localparam int CS  = patp_pkg::CURVE_STEPS;
  localparam int NCH = patp_pkg::NCH;
  localparam int CW  = patp_pkg::COORD_W;

  // alpha register
  logic [7:0] alpha;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= patp_pkg::ALPHA_RESET;
    end else if (cfg_write) begin
      alpha <= alpha_byte;
    end
  end

  // pipeline advance: everything from stage c on moves unless the result is held
  logic adv;
  logic sample_take;
  logic a_move, b_move, hazard;
  logic b_v;

  // stage a: input register
  logic               a_v;
  logic [9:0]         a_x;
  logic [8:0]         a_y;
  logic [15:0]        a_n;
  patp_pkg::hdr_t     a_s [NCH];

  assign sample_take  = sample_valid && !sample_stall;
  assign a_move       = a_v && (!b_v || b_move);
  assign sample_stall = a_v && b_v && !b_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (sample_take) begin
      a_v <= 1'b1;
    end else if (a_move) begin
      a_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      a_x    <= pixel_x;
      a_y    <= pixel_y;
      a_n    <= sample_count;
      a_s[0] <= sample_red;
      a_s[1] <= sample_green;
      a_s[2] <= sample_blue;
    end
  end

  // saturate coordinates and form the row-flipped linear address
  logic [CW-1:0]   xs, ys, row;
  logic [2*CW-1:0] addr_full;
  always_comb begin
    xs = (CW'(a_x) > CW'(FRAME_WIDTH - 1)) ? CW'(FRAME_WIDTH - 1) : CW'(a_x);
    ys = (CW'(a_y) > CW'(FRAME_HEIGHT - 1)) ? CW'(FRAME_HEIGHT - 1) : CW'(a_y);
    row = CW'(FRAME_HEIGHT - 1) - ys;
    addr_full = row * CW'(FRAME_WIDTH) + xs;
  end

  // stage b: address known, memory read issued when it moves on
  logic [AW-1:0]      b_addr;
  logic [15:0]        b_n;
  patp_pkg::hdr_t     b_s [NCH];

  assign b_move = b_v && adv && !hazard;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (a_move) begin
      b_v <= 1'b1;
    end else if (b_move) begin
      b_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_addr <= addr_full[AW-1:0];
      b_n    <= a_n;
      for (int ch = 0; ch < NCH; ch++) begin
        b_s[ch] <= a_s[ch];
      end
    end
  end

  // stage c: old accumulator value arrives from memory
  logic               c_v;
  logic [AW-1:0]      c_addr;
  logic [15:0]        c_n;
  patp_pkg::hdr_t     c_s [NCH];
  logic [3*24-1:0]    rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_move;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_addr <= b_addr;
      c_n    <= b_n;
      for (int ch = 0; ch < NCH; ch++) begin
        c_s[ch] <= b_s[ch];
      end
    end
  end

  // stage d: old * n (old forced to zero on a restart)
  logic               d_v;
  logic [AW-1:0]      d_addr;
  logic [16:0]        d_dvs;
  logic [39:0]        d_prod [NCH];
  patp_pkg::hdr_t     d_s [NCH];
  patp_pkg::hdr_t     old_sel [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      old_sel[ch] = (c_n == 16'd0) ? 24'd0 : rd[ch*24 +: 24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_addr <= c_addr;
      d_dvs  <= {1'b0, c_n} + 17'd1;
      for (int ch = 0; ch < NCH; ch++) begin
        d_prod[ch] <= {16'd0, old_sel[ch]} * {24'd0, c_n};
        d_s[ch]    <= c_s[ch];
      end
    end
  end

  // blend divider: (old*n + s) / (n+1), one quotient bit per stage
  logic [DS:0]        dv_v;
  logic [AW-1:0]      dv_addr [DS+1];
  logic [16:0]        dv_d    [DS+1];
  logic [16:0]        dv_r    [DS+1][NCH];
  logic [23:0]        dv_lq   [DS+1][NCH];
  logic [16:0]        dr_next [DS][NCH];
  logic [23:0]        dq_next [DS][NCH];
  logic [39:0]        d_sum   [NCH];

  always_comb begin
    logic [17:0] dsh;
    logic [17:0] dsub;
    logic        dge;
    for (int ch = 0; ch < NCH; ch++) begin
      d_sum[ch] = d_prod[ch] + {16'd0, d_s[ch]};
    end
    for (int k = 0; k < DS; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        dsh  = {dv_r[k][ch], dv_lq[k][ch][23]};
        dsub = dsh - {1'b0, dv_d[k]};
        dge  = (dsh >= {1'b0, dv_d[k]});
        dr_next[k][ch] = dge ? dsub[16:0] : dsh[16:0];
        dq_next[k][ch] = {dv_lq[k][ch][22:0], dge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else if (adv) begin
      dv_v <= {dv_v[DS-1:0], d_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_addr[0] <= d_addr;
      dv_d[0]    <= d_dvs;
      for (int ch = 0; ch < NCH; ch++) begin
        dv_r[0][ch]  <= {1'b0, d_sum[ch][39:24]};
        dv_lq[0][ch] <= d_sum[ch][23:0];
      end
      for (int k = 1; k <= DS; k++) begin
        dv_addr[k] <= dv_addr[k-1];
        dv_d[k]    <= dv_d[k-1];
        for (int ch = 0; ch < NCH; ch++) begin
          dv_r[k][ch]  <= dr_next[k-1][ch];
          dv_lq[k][ch] <= dq_next[k-1][ch];
        end
      end
    end
  end

  // accumulation memory: read at b on the move, write back the finished mean
  logic [3*24-1:0] acc_mem [PIX];
  logic [3*24-1:0] wr_word;
  assign wr_word = {dv_lq[DS][2], dv_lq[DS][1], dv_lq[DS][0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      rd <= acc_mem[b_addr];
    end
    if (adv && dv_v[DS]) begin
      acc_mem[dv_addr[DS]] <= wr_word;
    end
  end

  // interlock: hold b while its pixel is anywhere between read and write-back
  always_comb begin
    hazard = (c_v && (c_addr == b_addr)) || (d_v && (d_addr == b_addr));
    for (int k = 0; k <= DS; k++) begin
      hazard = hazard || (dv_v[k] && (dv_addr[k] == b_addr));
    end
  end

  // curve stage 1: x = max(0, c - offset), t = 6.2x
  logic               k1_v;
  logic [AW-1:0]      k1_addr;
  logic [23:0]        k1_x [NCH];
  logic [26:0]        k1_t [NCH];
  logic [23:0]        xo   [NCH];
  logic [42:0]        tp   [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      xo[ch] = (dv_lq[DS][ch] > patp_pkg::Q_OFFSET) ?
               dv_lq[DS][ch] - patp_pkg::Q_OFFSET : 24'd0;
      tp[ch] = {19'd0, xo[ch]} * {24'd0, patp_pkg::Q_SIX_TWO};
    end
  end

  // curve stage 2: numerator and denominator
  logic               k2_v;
  logic [AW-1:0]      k2_addr;
  logic [51:0]        k2_num [NCH];
  logic [52:0]        k2_den [NCH];
  logic [27:0]        ta     [NCH];
  logic [27:0]        tb     [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      ta[ch] = {1'b0, k1_t[ch]} + patp_pkg::Q_HALF;
      tb[ch] = {1'b0, k1_t[ch]} + patp_pkg::Q_ONE_SEVEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_v <= 1'b0;
      k2_v <= 1'b0;
    end else if (adv) begin
      k1_v <= dv_v[DS];
      k2_v <= k1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_addr <= dv_addr[DS];
      k2_addr <= k1_addr;
      for (int ch = 0; ch < NCH; ch++) begin
        k1_x[ch]   <= xo[ch];
        k1_t[ch]   <= tp[ch][42:16];
        k2_num[ch] <= {28'd0, k1_x[ch]} * {24'd0, ta[ch]};
        k2_den[ch] <= {29'd0, k1_x[ch]} * {25'd0, tb[ch]} + patp_pkg::Q32_ZERO_SIX;
      end
    end
  end

  // curve divider: 2559*num / (10*den), eight quotient bits
  logic [CS:0]        cv_v;
  logic [AW-1:0]      cv_addr [CS+1];
  logic [56:0]        cv_r    [CS+1][NCH];
  logic [56:0]        cv_dd   [CS+1][NCH];
  logic [7:0]         cv_q    [CS+1][NCH];
  logic [56:0]        cr_next [CS][NCH];
  logic [7:0]         cq_next [CS][NCH];
  logic [63:0]        n2      [NCH];
  logic [56:0]        dd      [NCH];

  always_comb begin
    logic [57:0] csh;
    logic [57:0] csub;
    logic        cge;
    for (int ch = 0; ch < NCH; ch++) begin
      n2[ch] = {1'b0, k2_num[ch], 11'd0} + {3'd0, k2_num[ch], 9'd0} - {12'd0, k2_num[ch]};
      dd[ch] = {1'b0, k2_den[ch], 3'd0} + {3'd0, k2_den[ch], 1'b0};
    end
    for (int k = 0; k < CS; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        csh  = {cv_r[k][ch], cv_q[k][ch][7]};
        csub = csh - {1'b0, cv_dd[k][ch]};
        cge  = (csh >= {1'b0, cv_dd[k][ch]});
        cr_next[k][ch] = cge ? csub[56:0] : csh[56:0];
        cq_next[k][ch] = {cv_q[k][ch][6:0], cge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_v <= '0;
    end else if (adv) begin
      cv_v <= {cv_v[CS-1:0], k2_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cv_addr[0] <= k2_addr;
      for (int ch = 0; ch < NCH; ch++) begin
        cv_r[0][ch]  <= {1'b0, n2[ch][63:8]};
        cv_q[0][ch]  <= n2[ch][7:0];
        cv_dd[0][ch] <= dd[ch];
      end
      for (int k = 1; k <= CS; k++) begin
        cv_addr[k] <= cv_addr[k-1];
        for (int ch = 0; ch < NCH; ch++) begin
          cv_r[k][ch]  <= cr_next[k-1][ch];
          cv_q[k][ch]  <= cq_next[k-1][ch];
          cv_dd[k][ch] <= cv_dd[k-1][ch];
        end
      end
    end
  end

  // result: the byte never exceeds 255 since num < den
  logic [AW+18:0] addr_ext;
  assign addr_ext      = {19'd0, cv_addr[CS]};
  assign result_valid  = cv_v[CS];
  assign adv           = !(result_valid && result_stall);
  assign pixel_address = addr_ext[18:0];
  assign rgba_word     = {cv_q[CS][0], cv_q[CS][1], cv_q[CS][2], alpha};

  // checks
  `PATP_ASSERT_IMPLY(a_no_read_write_clash, b_move && dv_v[DS], dv_addr[DS] != b_addr)
  `PATP_ASSERT_IMPLY(a_blend_rem_bound, dv_v[DS], dv_r[DS][0] < dv_d[DS])
  `PATP_ASSERT_IMPLY(a_curve_rem_bound, cv_v[CS], cv_r[CS][0] < cv_dd[CS][0])
  `PATP_ASSERT_NEXT(a_hold_on_interlock, b_v && !b_move, b_v && $stable(b_addr))
endmodule
`default_nettype wire

// ===== verif/progressive_accumulate_tonemap_pack_test.sv =====
// testbench for the hdr accumulate, filmic tone map and rgba pack block
`timescale 1ns / 100ps
`default_nettype none
module progressive_accumulate_tonemap_pack_test;

  localparam int FRAME_W    = 640;
  localparam int FRAME_H    = 480;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 60;    // longer than the latency from a sample to its result
  localparam int LONG_HOLD  = 150;
  localparam int POOL_SIZE  = 8;

  // curve constants as plain 64-bit numbers for the predictor
  localparam longint unsigned OFFSET_Q16   = 262;
  localparam longint unsigned SIX_TWO_Q16  = 406323;
  localparam longint unsigned HALF_Q16     = 32768;
  localparam longint unsigned ONE_SEVEN_Q16 = 111411;
  localparam longint unsigned ZERO_SIX_Q32 = 257698038;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [7:0]  alpha_byte;
  logic        sample_valid;
  logic        sample_stall;
  logic [9:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [15:0] sample_count;
  logic [23:0] sample_red;
  logic [23:0] sample_green;
  logic [23:0] sample_blue;
  logic        result_valid;
  logic        result_stall;
  logic [18:0] pixel_address;
  logic [31:0] rgba_word;

  progressive_accumulate_tonemap_pack #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .alpha_byte   (alpha_byte),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .sample_count (sample_count),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_address(pixel_address),
    .rgba_word    (rgba_word)
  );

  // one expected display pixel
  typedef struct {
    logic [18:0] addr;
    logic [31:0] word;
  } display_pixel_t;

  display_pixel_t pending_pixels[$];

  // predictor copy of the accumulation store, keyed by flat address;
  // an entry exists only once it has been written
  patp_pkg::hdr_t mean_red[int];
  patp_pkg::hdr_t mean_green[int];
  patp_pkg::hdr_t mean_blue[int];
  logic [7:0] alpha_now;

  int fail_count;
  int sent_count;
  int checked_count;
  int cycle_count;
  bit src_idle;    // sender inserts random gaps
  bit sink_idle;   // receiver inserts random stalls
  logic long_hold;
  int stall_left;
  event start_hold;

  // raw coordinates of written pixels, with the count each has reached
  logic [9:0]  pool_x[POOL_SIZE];
  logic [8:0]  pool_y[POOL_SIZE];
  int          pool_n[POOL_SIZE];

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  // saturate the coordinates and flip the row
  function automatic int flat_address(logic [9:0] x, logic [8:0] y);
    int sx, sy;
    sx = (x > FRAME_W - 1) ? FRAME_W - 1 : int'(x);
    sy = (y > FRAME_H - 1) ? FRAME_H - 1 : int'(y);
    return (FRAME_H - 1 - sy) * FRAME_W + sx;
  endfunction

  // running mean with weight 1/(n+1), exact floor
  function automatic patp_pkg::hdr_t running_mean(patp_pkg::hdr_t old, patp_pkg::hdr_t s,
                                                  logic [15:0] n);
    longint unsigned total, q;
    total = longint'(old) * longint'(n) + longint'(s);
    q = total / (longint'(n) + 1);
    return q[23:0];
  endfunction

  // filmic curve and byte quantization
  function automatic logic [7:0] filmic_byte(patp_pkg::hdr_t c);
    longint unsigned x, t, num, den, b;
    x = (longint'(c) > OFFSET_Q16) ? longint'(c) - OFFSET_Q16 : 64'd0;
    t = (SIX_TWO_Q16 * x) >> 16;
    num = x * (t + HALF_Q16);
    den = x * (t + ONE_SEVEN_Q16) + ZERO_SIX_Q32;
    b = (2559 * num) / (10 * den);
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  // fold one accepted sample into the store and queue its display pixel
  task automatic predict_pixel(logic [9:0] x, logic [8:0] y, logic [15:0] n,
                               patp_pkg::hdr_t r, patp_pkg::hdr_t g, patp_pkg::hdr_t b);
    int a;
    display_pixel_t p;
    a = flat_address(x, y);
    if (n == 0) begin
      mean_red[a] = r;
      mean_green[a] = g;
      mean_blue[a] = b;
    end else begin
      mean_red[a] = running_mean(mean_red[a], r, n);
      mean_green[a] = running_mean(mean_green[a], g, n);
      mean_blue[a] = running_mean(mean_blue[a], b, n);
    end
    p.addr = a[18:0];
    p.word = {filmic_byte(mean_red[a]), filmic_byte(mean_green[a]),
              filmic_byte(mean_blue[a]), alpha_now};
    pending_pixels.push_back(p);
  endtask

  // ---------------- result side ----------------

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    display_pixel_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: pixel_address %0d rgba_word %h",
               pixel_address, rgba_word);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        checked_count++;
        if (pixel_address !== want.addr) begin
          $error("pixel_address: expected %0d, got %0d", want.addr, pixel_address);
          fail_count++;
        end
        if (rgba_word !== want.word) begin
          $error("rgba_word: expected %h, got %h", want.word, rgba_word);
          fail_count++;
        end
      end
    end
  end

  // receiver: random wait after each transfer, plus the long hold
  always @(posedge clk) begin
    int nxt;
    if (result_valid && !result_stall)
      nxt = sink_idle ? $urandom_range(0, 12) : 0;
    else
      nxt = (stall_left > 0) ? stall_left - 1 : 0;
    stall_left <= nxt;
    result_stall <= long_hold || (nxt != 0);
  end

  // long receiver hold, counted here while the sender keeps going
  initial begin
    forever begin
      @(start_hold);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  // ---------------- sample side ----------------

  // offer one sample after a random gap and wait for its transfer
  task automatic send_sample(logic [9:0] x, logic [8:0] y, logic [15:0] n,
                             patp_pkg::hdr_t r, patp_pkg::hdr_t g, patp_pkg::hdr_t b);
    int gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    sample_count <= n;
    sample_red <= r;
    sample_green <= g;
    sample_blue <= b;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    predict_pixel(x, y, n, r, g, b);
    sent_count++;
  endtask

  // sender pauses until everything is back, then lets the pipe settle
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_alpha(logic [7:0] v);
    cfg_write <= 1'b1;
    alpha_byte <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    alpha_now = v;
  endtask

  // hdr value from a spread of magnitudes, the knee near the offset included
  function automatic patp_pkg::hdr_t pick_hdr();
    case ($urandom_range(0, 4))
      0: return patp_pkg::hdr_t'($urandom_range(0, 1024));
      1: return patp_pkg::hdr_t'($urandom_range(0, 32'h1_FFFF));
      2: return patp_pkg::hdr_t'($urandom_range(0, 32'h7_FFFF));
      default: return patp_pkg::hdr_t'($urandom_range(0, 32'hFF_FFFF));
    endcase
  endfunction

  // restart one pool pixel at fresh coordinates, anywhere in the raw range
  task automatic restart_pool(int i);
    pool_x[i] = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(640, 1023))
                                           : 10'($urandom_range(0, 1023));
    pool_y[i] = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(480, 511))
                                           : 9'($urandom_range(0, 511));
    pool_n[i] = 0;
  endtask

  // next sample of a pool pixel; once written, its count grows by one, or is random when noisy
  task automatic advance_pool(int i, bit noisy);
    logic [15:0] n;
    if (pool_n[i] == 0) n = 16'd0;
    else if (noisy) n = 16'($urandom_range(0, 65535));
    else n = 16'(pool_n[i]);
    send_sample(pool_x[i], pool_y[i], n, pick_hdr(), pick_hdr(), pick_hdr());
    pool_n[i] = (n == 16'hFFFF) ? 65535 : int'(n) + 1;
  endtask

  // ---------------- tests ----------------

  // field extremes, out-of-frame coordinates, count limits, curve knee
  task automatic test_field_extremes();
    send_sample(10'd0, 9'd0, 16'd0, 24'd0, 24'd0, 24'd0);
    send_sample(10'd0, 9'd0, 16'd1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_sample(10'd639, 9'd479, 16'd0, 24'hFF_FFFF, 24'd262, 24'd263);
    send_sample(10'd639, 9'd479, 16'd65535, 24'd0, 24'hFF_FFFF, 24'd0);
    // outside the frame: both coordinates saturate onto the corner above
    send_sample(10'd1023, 9'd511, 16'd65535, 24'hFF_FFFF, 24'd0, 24'h55_5555);
    send_sample(10'd640, 9'd480, 16'd2, 24'hAA_AAAA, 24'h00_0106, 24'd1);
    send_sample(10'd1023, 9'd0, 16'd0, 24'd261, 24'd262, 24'd264);
    send_sample(10'd0, 9'd511, 16'd0, 24'h01_0000, 24'h00_8000, 24'h10_0000);
    send_sample(10'd1023, 9'd0, 16'd32768, 24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFE);
    // same pixel back to back hits the read-modify-write window
    send_sample(10'd341, 9'd170, 16'd0, 24'h12_3456, 24'h65_4321, 24'h00_0FFF);
    send_sample(10'd341, 9'd170, 16'd1, 24'h00_0000, 24'h00_0001, 24'hF0_0000);
    send_sample(10'd341, 9'd170, 16'd2, 24'h3F_FFFF, 24'h00_0000, 24'h00_0000);
    send_sample(10'd682, 9'd341, 16'd0, 24'd0, 24'd0, 24'd0);
    drain_results();
  endtask

  // alpha register across its extremes and a few values in between
  task automatic test_alpha_settings();
    logic [7:0] settings[4] = '{8'd0, 8'h5A, 8'hA5, 8'd255};
    foreach (settings[k]) begin
      write_alpha(settings[k]);
      for (int i = 0; i < 4; i++) advance_pool(i, 1'b0);
      drain_results();
    end
  endtask

  // progressive sequences with random content, some noise and restarts
  task automatic test_progressive_sequences(int items);
    int i;
    for (int k = 0; k < items; k++) begin
      // switch idling on and off in stretches
      if (k % 60 == 0) begin
        src_idle = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
      end
      if (k % 150 == 149) begin
        drain_results();
        write_alpha(8'($urandom_range(0, 255)));
      end
      i = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 19) == 0) restart_pool(i);
      advance_pool(i, $urandom_range(0, 4) == 0);
    end
    drain_results();
  endtask

  // receiver holds off while samples keep coming, so the pipe fills up
  task automatic test_backpressure();
    src_idle = 0;
    sink_idle = 0;
    -> start_hold;
    for (int k = 0; k < 60; k++) advance_pool(k % POOL_SIZE, 1'b0);
    drain_results();
    src_idle = 1;
    sink_idle = 1;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    alpha_byte = 8'd0;
    sample_valid = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    sample_count = '0;
    sample_red = '0;
    sample_green = '0;
    sample_blue = '0;
    result_stall = 1'b0;
    long_hold = 1'b0;
    stall_left = 0;
    fail_count = 0;
    sent_count = 0;
    checked_count = 0;
    cycle_count = 0;
    src_idle = 1;
    sink_idle = 1;
    alpha_now = patp_pkg::ALPHA_RESET;
    for (int i = 0; i < POOL_SIZE; i++) restart_pool(i);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_alpha_settings();
    test_backpressure();
    test_progressive_sequences(420);

    $display("covered %0d samples, %0d results checked: saturated coordinates,",
             sent_count, checked_count);
    $display("count limits, same-pixel hazards, alpha settings, long result stall");
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
